// ===== src/mop_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot orbit period block.
// Used by mop_mul, mop_cell and mandelbrot_orbit_period_top. No dependencies.

package mop_pkg;

    // Default depth of the orbit store (one cell per orbit point).
    localparam int ORBIT_DEPTH_DEF = 64;

    // Field and register widths.
    localparam int Q_W      = 48;   // Q24.24 orbit values
    localparam int IN_W     = 32;   // Q4.28 input parts
    localparam int ITER_W   = 7;
    localparam int TOL_W    = 25;
    localparam int LIM_W    = 47;
    localparam int PERIOD_W = 6;
    localparam int IDX_W    = 2;

    // Edges from an update of z until the new z sits in its register.
    localparam int PIPE_LAT = 5;

    // Register reset values.
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(64);
    localparam logic [TOL_W-1:0]  TOL_RST      = TOL_W'(17);
    localparam logic [LIM_W-1:0]  LIM_RST      = LIM_W'(64'd167772160000);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MAX_ITER = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_TOL      = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_LIMIT    = IDX_W'(2);

    // Commands broadcast to every orbit cell.
    typedef struct packed {
        logic clear;     // forget all stored points
        logic write;     // first empty cell takes the new point
        logic compare;   // every cell compares the new point with its own
        logic shift;     // every cell takes its upper neighbor's contents
    } mop_ctrl_t;

    // Contents of one orbit cell, as seen by its lower neighbor.
    typedef struct packed {
        logic          filled;
        logic          match;
        logic [Q_W-1:0] re;
        logic [Q_W-1:0] im;
    } mop_entry_t;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_DECIDE = 7'b0001000,
        ST_SEEK   = 7'b0010000,
        ST_EMIT   = 7'b0100000,
        ST_ZERO   = 7'b1000000
    } mop_state_t;

    // Clamp a 50-bit signed sum to the 48-bit signed range.
    function automatic logic [Q_W-1:0] sat48(input logic [Q_W+1:0] v);
        logic [Q_W-1:0] r;
        begin
            if ((v[Q_W+1:Q_W-1] == 3'b000) || (v[Q_W+1:Q_W-1] == 3'b111))
            begin
                r = v[Q_W-1:0];
            end
            else if (v[Q_W+1])
            begin
                r = {1'b1, {(Q_W-1){1'b0}}};
            end
            else
            begin
                r = {1'b0, {(Q_W-1){1'b1}}};
            end
            return r;
        end
    endfunction

endpackage

// ===== src/mop_mul.sv =====
// Four-stage Q24.24 multiplier with truncation toward zero and saturation.
// Depends on mop_pkg for widths.

module mop_mul import mop_pkg::*;
(
    input  logic           clk,
    input  logic [Q_W-1:0] a,
    input  logic [Q_W-1:0] b,
    output logic [Q_W-1:0] p
);

    localparam int H = Q_W / 2;
    localparam logic [Q_W+1:0] MAG_CAP = (Q_W+2)'(1) << (Q_W - 1);

    logic [Q_W-1:0] ua;
    logic [Q_W-1:0] ub;
    logic [H-1:0]   ah_reg, al_reg, bh_reg, bl_reg;
    logic           neg_a_reg, neg_b_reg, neg_c_reg;
    logic [Q_W-1:0] hh_reg, m1_reg, m2_reg, m3_reg;
    logic           sat_hi_reg;
    logic [Q_W+1:0] sum_reg;
    logic [Q_W-1:0] mag;
    logic [Q_W-1:0] p_next;
    logic [Q_W-1:0] p_reg;

    // Stage A: magnitudes split into 24-bit halves.
    always_comb
    begin
        ua = a[Q_W-1] ? (~a + 1'b1) : a;
        ub = b[Q_W-1] ? (~b + 1'b1) : b;
    end

    always_ff @(posedge clk)
    begin
        ah_reg    <= ua[Q_W-1:H];
        al_reg    <= ua[H-1:0];
        bh_reg    <= ub[Q_W-1:H];
        bl_reg    <= ub[H-1:0];
        neg_a_reg <= a[Q_W-1] ^ b[Q_W-1];
    end

    // Stage B: the four partial products, each a 24 by 24 multiply.
    always_ff @(posedge clk)
    begin
        hh_reg    <= ah_reg * bh_reg;
        m1_reg    <= ah_reg * bl_reg;
        m2_reg    <= al_reg * bh_reg;
        m3_reg    <= al_reg * bl_reg;
        neg_b_reg <= neg_a_reg;
    end

    // Stage C: sum the partial products; a large high product saturates.
    always_ff @(posedge clk)
    begin
        sat_hi_reg <= |hh_reg[Q_W-1:H-1];
        sum_reg    <= (Q_W+2)'({hh_reg[H-2:0], {H{1'b0}}})
                    + (Q_W+2)'(m1_reg)
                    + (Q_W+2)'(m2_reg)
                    + (Q_W+2)'(m3_reg[Q_W-1:H]);
        neg_c_reg  <= neg_b_reg;
    end

    // Stage D: clamp the magnitude and apply the sign.
    always_comb
    begin
        if (sat_hi_reg || (sum_reg > MAG_CAP))
        begin
            mag = MAG_CAP[Q_W-1:0];
        end
        else
        begin
            mag = sum_reg[Q_W-1:0];
        end

        if (neg_c_reg)
        begin
            p_next = ~mag + 1'b1;
        end
        else if (mag[Q_W-1])
        begin
            p_next = {1'b0, {(Q_W-1){1'b1}}};
        end
        else
        begin
            p_next = mag;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== src/mop_cell.sv =====
// One orbit cell: holds one stored orbit point, compares it with a new point
// and passes its contents down the chain. Depends on mop_pkg.

module mop_cell import mop_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mop_ctrl_t        ctrl,
    input  logic             below_filled,
    input  mop_entry_t       upper,
    input  logic [Q_W-1:0]   new_real,
    input  logic [Q_W-1:0]   new_imag,
    input  logic [TOL_W-1:0] tol,
    output mop_entry_t       entry
);

    logic           filled_reg, filled_next;
    logic           match_reg, match_next;
    logic [Q_W-1:0] re_reg;
    logic [Q_W-1:0] im_reg;
    logic [Q_W:0]   diff_re, diff_im;
    logic [Q_W:0]   mag_re, mag_im;
    logic           close;
    logic           write_here;

    // Absolute distance on both parts, strictly below the tolerance.
    always_comb
    begin
        diff_re = {re_reg[Q_W-1], re_reg} - {new_real[Q_W-1], new_real};
        diff_im = {im_reg[Q_W-1], im_reg} - {new_imag[Q_W-1], new_imag};
        mag_re  = diff_re[Q_W] ? (~diff_re + 1'b1) : diff_re;
        mag_im  = diff_im[Q_W] ? (~diff_im + 1'b1) : diff_im;
        close   = (mag_re < (Q_W+1)'(tol)) && (mag_im < (Q_W+1)'(tol));
    end

    // The first empty cell above a filled one takes the new point.
    assign write_here = ctrl.write && !filled_reg && below_filled;

    always_comb
    begin
        filled_next = filled_reg;
        match_next  = match_reg;
        if (ctrl.clear)
        begin
            filled_next = 1'b0;
            match_next  = 1'b0;
        end
        else if (ctrl.shift)
        begin
            filled_next = upper.filled;
            match_next  = upper.match;
        end
        else
        begin
            if (write_here)
            begin
                filled_next = 1'b1;
            end
            if (ctrl.compare)
            begin
                match_next = filled_reg && close;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            match_reg  <= match_next;
        end
    end

    // Stored point: shifted down from above or written from the new point.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            re_reg <= upper.re;
            im_reg <= upper.im;
        end
        else if (write_here)
        begin
            re_reg <= new_real;
            im_reg <= new_imag;
        end
    end

    assign entry.filled = filled_reg;
    assign entry.match  = match_reg;
    assign entry.re     = re_reg;
    assign entry.im     = im_reg;

endmodule

// ===== src/mandelbrot_orbit_period_top.sv =====
// Top level of the Mandelbrot orbit period block: controller, z registers,
// three mop_mul units and a chain of mop_cell orbit cells. Depends on mop_pkg.
//
//   Channel   Handshake             Payload                      Dir
//   in        in_valid/in_ready     c_real, c_imag               input
//   out       out_valid/out_ready   period, cycle_real, last     output
//   cfg       cfg_valid/cfg_ready   cfg_index, cfg_data          input
//
// One point at a time. Each orbit step runs through the multiplier pipeline
// and the z update, then stores and compares in all cells at once, then
// decides; an escaping step ends at the check. After a match the chain shifts
// down to the first cycle member, and the result goes out one beat per cycle
// while the output is not stalled.
// Reset clears the controller, the configuration registers and the cell flags; stored points need no reset.
// A stalled output holds its beat; the next point is taken once the last beat
// of the current one is in the output register.

module mandelbrot_orbit_period_top import mop_pkg::*;
#(
    parameter int ORBIT_DEPTH = ORBIT_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_W-1:0]     c_real,
    input  logic [IN_W-1:0]     c_imag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PERIOD_W-1:0] period,
    output logic [Q_W-1:0]      cycle_real,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [LIM_W-1:0]    cfg_data
);

    localparam int CW      = $clog2(ORBIT_DEPTH + 1);
    localparam int NW      = $clog2(ORBIT_DEPTH);
    localparam int TIMER_W = $clog2(PIPE_LAT);

    // Configuration registers.
    logic [ITER_W-1:0] max_iter_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [LIM_W-1:0]  lim_reg;

    // Controller state.
    mop_state_t           state_reg, state_next;
    logic [TIMER_W-1:0]   timer_reg, timer_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        steps_reg, steps_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        n_reg, n_next;
    logic                 out_valid_reg, out_valid_next;

    // Orbit values.
    logic [Q_W-1:0] zr_reg, zr_next;
    logic [Q_W-1:0] zi_reg, zi_next;
    logic [Q_W-1:0] cr_reg, cr_next;
    logic [Q_W-1:0] ci_reg, ci_next;
    logic [Q_W-1:0] nr_reg, ni_reg;
    logic [Q_W-1:0] prod_rr, prod_ii, prod_ri;
    logic [Q_W+1:0] re_sum, im_sum;

    // Output beat.
    logic [PERIOD_W-1:0] out_period_reg;
    logic [Q_W-1:0]      out_real_reg;
    logic                out_last_reg;
    logic                load_out;
    logic [PERIOD_W-1:0] beat_period;
    logic [Q_W-1:0]      beat_real;
    logic                beat_last;

    logic                slot_free;
    logic                escape;
    logic                any_match;
    logic [CW-1:0]       steps_cfg;
    mop_ctrl_t           cell_ctrl;
    mop_entry_t          chain [ORBIT_DEPTH:0];
    logic [ORBIT_DEPTH-1:0] match_vec;

    // Configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RST;
            tol_reg      <= TOL_RST;
            lim_reg      <= LIM_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_ITER: max_iter_reg <= cfg_data[ITER_W-1:0];
                REG_TOL:      tol_reg      <= cfg_data[TOL_W-1:0];
                REG_LIMIT:    lim_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Step count limited by the store depth.
    assign steps_cfg = (max_iter_reg > ITER_W'(ORBIT_DEPTH)) ? CW'(ORBIT_DEPTH)
                                                             : CW'(max_iter_reg);

    // Products of the current z.
    mop_mul u_mul_rr (.clk(clk), .a(zr_reg), .b(zr_reg), .p(prod_rr));
    mop_mul u_mul_ii (.clk(clk), .a(zi_reg), .b(zi_reg), .p(prod_ii));
    mop_mul u_mul_ri (.clk(clk), .a(zr_reg), .b(zi_reg), .p(prod_ri));

    // Next z: exact sums of the saturated products, then saturated.
    always_comb
    begin
        re_sum = {{2{prod_rr[Q_W-1]}}, prod_rr} - {{2{prod_ii[Q_W-1]}}, prod_ii}
               + {{2{cr_reg[Q_W-1]}}, cr_reg};
        im_sum = {prod_ri[Q_W-1], prod_ri, 1'b0} + {{2{ci_reg[Q_W-1]}}, ci_reg};
    end

    always_ff @(posedge clk)
    begin
        nr_reg <= sat48(re_sum);
        ni_reg <= sat48(im_sum);
    end

    // Only positive parts can pass the limit.
    assign escape = ($signed(nr_reg) > $signed({1'b0, lim_reg}))
                 || ($signed(ni_reg) > $signed({1'b0, lim_reg}));

    // Chain of orbit cells; cell 0 holds the oldest point.
    assign chain[ORBIT_DEPTH] = '0;

    for (genvar p = 0; p < ORBIT_DEPTH; p++)
    begin : g_cell
        logic below;

        if (p == 0)
        begin : g_first
            assign below = 1'b1;
        end
        else
        begin : g_rest
            assign below = chain[p-1].filled;
        end

        mop_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .below_filled (below),
            .upper        (chain[p+1]),
            .new_real     (nr_reg),
            .new_imag     (ni_reg),
            .tol          (tol_reg),
            .entry        (chain[p])
        );

        assign match_vec[p] = chain[p].match;
    end

    assign any_match = |match_vec;
    assign slot_free = !out_valid_reg || out_ready;

    // Controller.
    always_comb
    begin
        state_next  = state_reg;
        timer_next  = timer_reg;
        i_next      = i_reg;
        steps_next  = steps_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        cell_ctrl   = '0;
        load_out    = 1'b0;
        beat_period = '0;
        beat_real   = '0;
        beat_last   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    zr_next         = '0;
                    zi_next         = '0;
                    cr_next         = {{(Q_W-IN_W+4){c_real[IN_W-1]}}, c_real[IN_W-1:4]};
                    ci_next         = {{(Q_W-IN_W+4){c_imag[IN_W-1]}}, c_imag[IN_W-1:4]};
                    i_next          = '0;
                    steps_next      = steps_cfg;
                    timer_next      = '0;
                    cell_ctrl.clear = 1'b1;
                    state_next      = (steps_cfg == '0) ? ST_ZERO : ST_MUL;
                end
            end

            ST_MUL:
            begin
                timer_next = timer_reg + 1'b1;
                if (timer_reg == TIMER_W'(PIPE_LAT - 1))
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                if (escape)
                begin
                    state_next = ST_ZERO;
                end
                else
                begin
                    cell_ctrl.write   = 1'b1;
                    cell_ctrl.compare = 1'b1;
                    zr_next           = nr_reg;
                    zi_next           = ni_reg;
                    cnt_next          = NW'(i_reg);
                    i_next            = i_reg + 1'b1;
                    state_next        = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (any_match)
                begin
                    state_next = ST_SEEK;
                end
                else if (i_reg == steps_reg)
                begin
                    state_next = ST_ZERO;
                end
                else
                begin
                    timer_next = '0;
                    state_next = ST_MUL;
                end
            end

            // Shift down until the oldest matching point sits in cell 0.
            ST_SEEK:
            begin
                if (chain[0].match)
                begin
                    n_next     = cnt_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cell_ctrl.shift = 1'b1;
                    cnt_next        = cnt_reg - 1'b1;
                end
            end

            // One cycle member per beat, oldest first.
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    load_out        = 1'b1;
                    beat_period     = PERIOD_W'(n_reg);
                    beat_real       = chain[0].re;
                    beat_last       = (cnt_reg == NW'(1));
                    cell_ctrl.shift = 1'b1;
                    cnt_next        = cnt_reg - 1'b1;
                    if (cnt_reg == NW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // Escape or no cycle: a single period-zero beat.
            ST_ZERO:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            timer_reg     <= '0;
            i_reg         <= '0;
            steps_reg     <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timer_reg     <= timer_next;
            i_reg         <= i_next;
            steps_reg     <= steps_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Orbit and output payload registers.
    always_ff @(posedge clk)
    begin
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        if (load_out)
        begin
            out_period_reg <= beat_period;
            out_real_reg   <= beat_real;
            out_last_reg   <= beat_last;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign period     = out_period_reg;
    assign cycle_real = out_real_reg;
    assign last       = out_last_reg;

endmodule
